[src/rm_edf_tick_scheduler_macros.svh]
// Assertion macros used by the scheduler top module.
`ifndef RM_EDF_TICK_SCHEDULER_MACROS_SVH
`define RM_EDF_TICK_SCHEDULER_MACROS_SVH

// Implication checked on the same clock edge.
`define RMEDF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Implication checked on the following clock edge.
`define RMEDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

[src/rmedf_pkg.sv]
package rmedf_pkg;

  localparam int DEF_MAX_TASKS = 8;
  localparam int DEF_MAX_JOBS  = 16;
  // Wide enough for the largest slot count the design supports.
  localparam int SLOT_IDX_W    = 8;

  localparam logic CMD_DEFINE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic REG_POLICY    = 1'b0;
  localparam logic REG_KILL_LATE = 1'b1;

  localparam logic POL_RM  = 1'b0;
  localparam logic POL_EDF = 1'b1;

  // Best job seen so far, handed from cell to cell.
  typedef struct packed {
    logic                  hit;
    logic [32:0]           key;
    logic [2:0]            task_id;
    logic [15:0]           job;
    logic [15:0]           done;
    logic [SLOT_IDX_W-1:0] idx;
  } cand_t;

  // Job written into a free slot on release.
  typedef struct packed {
    logic [2:0]  task_id;
    logic [15:0] job;
    logic [32:0] deadline;
    logic [15:0] period;
    logic [15:0] need;
  } slot_load_t;

  // Control broadcast to every slot cell.
  typedef struct packed {
    logic                  policy;
    logic                  kill_late;
    logic                  check;
    logic [31:0]           now;
    logic                  win;
    logic [SLOT_IDX_W-1:0] win_idx;
  } slot_ctrl_t;

endpackage

[src/rm_edf_tick_scheduler.sv]
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    cmd, task_index, task_start, task_period,
//                                             task_exec, now
// out       output     out_valid / out_ready  busy_res, run_task, run_job, run_step,
//                                             misses_now, miss_total, active_ticks, overflow
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// A define request goes from idle straight to output. A tick request runs the release test
// on each task, with a one-bit-per-cycle remainder unit per defined task of nonzero period
// whose start has come, then the miss check, the selection over the slot row and output.
// Reset is synchronous and clears all tasks, slots and counters.
// A result waits in the output register while the next request is accepted;
// a request finishing while the previous result is still held stalls until it is taken.
module rm_edf_tick_scheduler #(
  parameter int MAX_TASKS = rmedf_pkg::DEF_MAX_TASKS,
  parameter int MAX_JOBS  = rmedf_pkg::DEF_MAX_JOBS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [2:0]  task_index,
  input  logic [31:0] task_start,
  input  logic [15:0] task_period,
  input  logic [15:0] task_exec,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        busy_res,
  output logic [2:0]  run_task,
  output logic [15:0] run_job,
  output logic [15:0] run_step,
  output logic [4:0]  misses_now,
  output logic [31:0] miss_total,
  output logic [31:0] active_ticks,
  output logic        overflow,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import rmedf_pkg::*;
  `include "rm_edf_tick_scheduler_macros.svh"

  localparam int TIW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SIW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW  = $clog2(MAX_JOBS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REL    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_SELECT = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0] state;
  logic       policy;
  logic       kill_late;

  // Task table.
  logic [MAX_TASKS-1:0] task_valid;
  logic [31:0]          task_begin [MAX_TASKS];
  logic [15:0]          task_per   [MAX_TASKS];
  logic [15:0]          task_need  [MAX_TASKS];
  logic [15:0]          task_jobs  [MAX_TASKS];

  logic [TIW-1:0] tcnt;
  logic [CW-1:0]  scnt;
  logic [31:0]    tick_now;
  logic [31:0]    misses_sum;
  logic [31:0]    ticks_active;

  // Result being built.
  logic        res_busy;
  logic [2:0]  res_task;
  logic [15:0] res_job;
  logic [15:0] res_step;
  logic [4:0]  res_misses;
  logic        res_ovf;

  // Slot row.
  slot_ctrl_t            ctrl;
  slot_load_t            load_data;
  logic [MAX_JOBS-1:0]   load_vec;
  logic [MAX_JOBS-1:0]   slot_valid;
  logic [MAX_JOBS-1:0]   miss_vec;
  cand_t                 chain [MAX_JOBS+1];
  logic                  win;

  // Remainder unit.
  logic div_start;
  logic div_done;
  logic div_zero;

  logic [SIW-1:0] free_idx;
  logic           free_any;
  logic           task_due;
  logic           last_task;
  logic [CW-1:0]  miss_cnt;
  logic [4:0]     miss_sat;
  logic [32:0]    miss_add;

  assign in_ready  = (state == ST_IDLE);
  assign last_task = (tcnt == TIW'(MAX_TASKS - 1));
  assign task_due  = task_valid[tcnt] && (task_per[tcnt] != 16'd0)
                     && (tick_now >= task_begin[tcnt]);
  assign div_start = (state == ST_REL) && task_due;
  // The last cell's output reflects the whole checked row once the best job has passed
  // through the register of every cell, and only then is the winner taken.
  assign win       = (state == ST_SELECT) && (scnt == CW'(MAX_JOBS)) && chain[MAX_JOBS].hit;

  rmedf_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tick_now - task_begin[tcnt]),
    .divisor  (task_per[tcnt]),
    .done     (div_done),
    .rem_zero (div_zero)
  );

  // Lowest free slot takes the next released job.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = SIW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    ctrl.policy    = policy;
    ctrl.kill_late = kill_late;
    ctrl.check     = (state == ST_CHECK);
    ctrl.now       = tick_now;
    ctrl.win       = win;
    ctrl.win_idx   = chain[MAX_JOBS].idx;
    load_data.task_id  = 3'(tcnt);
    load_data.job      = task_jobs[tcnt];
    load_data.deadline = {1'b0, tick_now} + {17'd0, task_per[tcnt]};
    load_data.period   = task_per[tcnt];
    load_data.need     = task_need[tcnt];
    load_vec = '0;
    if (state == ST_DIV && div_done && div_zero && free_any) load_vec[free_idx] = 1'b1;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    rmedf_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .load      (load_vec[g]),
      .load_data (load_data),
      .cand_in   (chain[g]),
      .cand_out  (chain[g+1]),
      .valid     (slot_valid[g]),
      .miss      (miss_vec[g])
    );
  end

  assign miss_cnt = CW'($countones(miss_vec));
  assign miss_sat = (32'(miss_cnt) >= 32'd31) ? 5'd31 : 5'(miss_cnt);
  assign miss_add = {1'b0, misses_sum} + 33'(miss_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      policy       <= POL_RM;
      kill_late    <= 1'b0;
      task_valid   <= '0;
      misses_sum   <= 32'd0;
      ticks_active <= 32'd0;
      out_valid    <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) task_jobs[i] <= 16'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_POLICY) policy <= cfg_data;
        else kill_late <= cfg_data;
      end
      if (state == ST_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            tick_now   <= now;
            tcnt       <= '0;
            res_busy   <= 1'b0;
            res_task   <= 3'd0;
            res_job    <= 16'd0;
            res_step   <= 16'd0;
            res_misses <= 5'd0;
            res_ovf    <= 1'b0;
            if (cmd == CMD_DEFINE) begin
              if (32'(task_index) < 32'(MAX_TASKS)) begin
                task_valid[TIW'(task_index)] <= 1'b1;
                task_begin[TIW'(task_index)] <= task_start;
                task_per[TIW'(task_index)]   <= task_period;
                task_need[TIW'(task_index)]  <= task_exec;
                task_jobs[TIW'(task_index)]  <= 16'd0;
              end
              state <= ST_OUT;
            end else begin
              state <= ST_REL;
            end
          end
        end
        ST_REL: begin
          if (task_due) state <= ST_DIV;
          else if (last_task) state <= ST_CHECK;
          else tcnt <= tcnt + TIW'(1);
        end
        ST_DIV: begin
          if (div_done) begin
            if (div_zero) begin
              if (!free_any) res_ovf <= 1'b1;
              task_jobs[tcnt] <= task_jobs[tcnt] + 16'd1;
            end
            if (last_task) begin
              state <= ST_CHECK;
            end else begin
              tcnt  <= tcnt + TIW'(1);
              state <= ST_REL;
            end
          end
        end
        ST_CHECK: begin
          res_misses <= miss_sat;
          misses_sum <= miss_add[32] ? 32'hFFFF_FFFF : miss_add[31:0];
          scnt       <= '0;
          state      <= ST_SELECT;
        end
        ST_SELECT: begin
          // The best job ripples one cell per cycle down the row.
          if (scnt == CW'(MAX_JOBS)) begin
            if (chain[MAX_JOBS].hit) begin
              res_busy <= 1'b1;
              res_task <= chain[MAX_JOBS].task_id;
              res_job  <= chain[MAX_JOBS].job;
              res_step <= chain[MAX_JOBS].done + 16'd1;
              if (ticks_active != 32'hFFFF_FFFF) ticks_active <= ticks_active + 32'd1;
            end
            state <= ST_OUT;
          end else begin
            scnt <= scnt + CW'(1);
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            busy_res     <= res_busy;
            run_task     <= res_task;
            run_job      <= res_job;
            run_step     <= res_step;
            misses_now   <= res_misses;
            overflow     <= res_ovf;
            miss_total   <= misses_sum;
            active_ticks <= ticks_active;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `RMEDF_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != ST_IDLE)
  `RMEDF_ASSERT_SAME(a_busy_counted, out_valid && busy_res, active_ticks != 32'd0)
  `RMEDF_ASSERT_SAME(a_miss_counted, out_valid && misses_now != 5'd0, miss_total != 32'd0)
  `RMEDF_ASSERT_SAME(a_div_only_release, div_done, state == ST_DIV)

endmodule

[src/rmedf_mod.sv]
module rmedf_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic        rem_zero
);
  // Restoring remainder, one dividend bit per cycle.
  logic [16:0] rem;
  logic [31:0] dvd;
  logic [5:0]  cnt;
  logic        run;
  logic [16:0] rem_sh;
  logic [16:0] rem_next;

  assign rem_sh   = {rem[15:0], dvd[31]};
  assign rem_next = (rem_sh >= {1'b0, divisor}) ? rem_sh - {1'b0, divisor} : rem_sh;
  assign rem_zero = (rem == 17'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd0;
        rem <= 17'd0;
        dvd <= dividend;
      end else if (run) begin
        rem <= rem_next;
        dvd <= {dvd[30:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[src/rmedf_cell.sv]
module rmedf_cell #(
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rmedf_pkg::slot_ctrl_t  ctrl,
  input  logic                   load,
  input  rmedf_pkg::slot_load_t  load_data,
  input  rmedf_pkg::cand_t       cand_in,
  output rmedf_pkg::cand_t       cand_out,
  output logic                   valid,
  output logic                   miss
);
  import rmedf_pkg::*;

  logic        missed;
  logic [2:0]  task_id;
  logic [15:0] job;
  logic [32:0] deadline;
  logic [15:0] period;
  logic [15:0] need;
  logic [15:0] done;
  logic [32:0] key;
  logic        mine;

  assign key  = (ctrl.policy == POL_EDF) ? deadline : {17'd0, period};
  assign miss = valid && !missed && ctrl.check && ({1'b0, ctrl.now} >= deadline)
                && (done != need);

  // This slot takes over the chain when it strictly outranks the incoming best.
  always_comb begin
    mine = 1'b0;
    if (valid) begin
      if (!cand_in.hit) mine = 1'b1;
      else if (key != cand_in.key) mine = key < cand_in.key;
      else if (task_id != cand_in.task_id) mine = task_id < cand_in.task_id;
      else mine = job < cand_in.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      cand_out.hit <= 1'b0;
    end else begin
      if (mine) begin
        cand_out <= '{hit: 1'b1, key: key, task_id: task_id, job: job, done: done,
                      idx: SLOT_IDX_W'(IDX)};
      end else begin
        cand_out <= cand_in;
      end
      if (load) begin
        valid    <= 1'b1;
        missed   <= 1'b0;
        task_id  <= load_data.task_id;
        job      <= load_data.job;
        deadline <= load_data.deadline;
        period   <= load_data.period;
        need     <= load_data.need;
        done     <= 16'd0;
      end else if (ctrl.check) begin
        if (miss) missed <= 1'b1;
        valid <= valid && !(miss && ctrl.kill_late) && !(done >= need);
      end else if (ctrl.win && ctrl.win_idx == SLOT_IDX_W'(IDX)) begin
        done <= done + 16'd1;
      end
    end
  end
endmodule
